>>> hw/rtl/b85dec_pkg.sv
// package for the base85 text-to-word decoder: result kinds, character codes
// and the alphabet-to-digit lookup
// no dependencies
`timescale 1ns / 1ps

package b85dec_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned DigitW = 7;
  localparam int unsigned CntW   = 3;
  localparam int unsigned KindW  = 2;

  // digits in one group
  localparam logic [CntW-1:0] GroupLen = CntW'(5);

  localparam logic [CharW-1:0] CharNul = 8'h00;
  localparam logic [CharW-1:0] CharEnd = 8'h5d;  // ']'

  typedef enum logic [KindW-1:0] {
    KIND_WORD = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic              valid;
    logic [DigitW-1:0] digit;
  } digit_t;

  // alphabet: 0-9 A-Z a-z ! # $ % & ( ) * + - ; < = > ? @ ^ _ ` { | } ~
  function automatic digit_t digit_of(input logic [CharW-1:0] c);
    digit_t r;
    logic [CharW-1:0] t;
    r.valid = 1'b1;
    r.digit = '0;
    t = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'd48;
      r.digit = t[DigitW-1:0];
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'd55;
      r.digit = t[DigitW-1:0];
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      t = c - 8'd61;
      r.digit = t[DigitW-1:0];
    end else begin
      case (c)
        8'h21:   r.digit = 7'd62;  // !
        8'h23:   r.digit = 7'd63;  // #
        8'h24:   r.digit = 7'd64;  // $
        8'h25:   r.digit = 7'd65;  // %
        8'h26:   r.digit = 7'd66;  // &
        8'h28:   r.digit = 7'd67;  // (
        8'h29:   r.digit = 7'd68;  // )
        8'h2a:   r.digit = 7'd69;  // *
        8'h2b:   r.digit = 7'd70;  // +
        8'h2d:   r.digit = 7'd71;  // -
        8'h3b:   r.digit = 7'd72;  // ;
        8'h3c:   r.digit = 7'd73;  // <
        8'h3d:   r.digit = 7'd74;  // =
        8'h3e:   r.digit = 7'd75;  // >
        8'h3f:   r.digit = 7'd76;  // ?
        8'h40:   r.digit = 7'd77;  // @
        8'h5e:   r.digit = 7'd78;  // ^
        8'h5f:   r.digit = 7'd79;  // _
        8'h60:   r.digit = 7'd80;  // `
        8'h7b:   r.digit = 7'd81;  // {
        8'h7c:   r.digit = 7'd82;  // |
        8'h7d:   r.digit = 7'd83;  // }
        8'h7e:   r.digit = 7'd84;  // ~
        default: r.valid = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/base85_text_to_word_decoder_core.sv
// base85 text-to-word decoder core: one character per beat in, one decoded
// word, end marker or error per group out
// depends on b85dec_pkg
`timescale 1ns / 1ps

// usage
// - slave stream: one text character per beat in s_axis_tdata_i
// - master stream: one result per beat, word in m_axis_tdata_o, result kind
//   in m_axis_tuser_o (word, end of stream, invalid character)
// - five alphabet characters make one word, emitted with its bytes reversed;
//   a nul at group start is dropped, a ']' at group start gives an end beat,
//   any other non-alphabet character gives an error beat and drops the group
// - a character is registered at the input, decoded against the group state
//   and the result written to the result register when the decode stage
//   advances; m_axis_tvalid_o comes straight from the result register
// - throughput: one character per cycle while no result waits, set by the single
//   multiply-by-85 and add between the input register and the result register
// - when the receiver stalls, the result register holds; the input register
//   still takes one more beat if it is empty, after which s_axis_tready_o falls
//   until the result is taken
// - reset clears both valid flags, the group value and the digit count

module base85_text_to_word_decoder_core
  import b85dec_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // input beats
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [CharW-1:0] s_axis_tdata_i,   // [7:0] char_code
  // result beats
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [WordW-1:0] m_axis_tdata_o,   // [31:0] word_out
  output logic [KindW-1:0] m_axis_tuser_o    // [1:0] kind
);

  // input register
  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;

  // group state
  logic [WordW-1:0] group_q, group_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_word_q, out_word_d;
  kind_e            out_kind_q, out_kind_d;

  logic             advance;
  logic             has_res;
  digit_t           dig;
  logic [WordW-1:0] acc;
  logic [CntW-1:0]  cnt_inc;

  // the decode stage moves whenever the result register is free or drains
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
    end
  end

  assign dig     = digit_of(in_char_q);
  // value * 85 as shifts and adds, modulo 2^32
  assign acc     = (group_q << 6) + (group_q << 4) + (group_q << 2) + group_q
                   + WordW'(dig.digit);
  assign cnt_inc = cnt_q + CntW'(1);

  // decode of the registered character against the group state
  always_comb begin
    group_d    = group_q;
    cnt_d      = cnt_q;
    has_res    = 1'b0;
    out_word_d = '0;
    out_kind_d = KIND_WORD;
    if (cnt_q == '0 && in_char_q == CharNul) begin
      // skipped between groups
    end else if (cnt_q == '0 && in_char_q == CharEnd) begin
      has_res    = 1'b1;
      out_kind_d = KIND_END;
      group_d    = '0;
    end else if (!dig.valid) begin
      has_res    = 1'b1;
      out_kind_d = KIND_ERR;
      group_d    = '0;
      cnt_d      = '0;
    end else if (cnt_inc == GroupLen) begin
      has_res    = 1'b1;
      out_kind_d = KIND_WORD;
      out_word_d = {acc[7:0], acc[15:8], acc[23:16], acc[31:24]};
      group_d    = '0;
      cnt_d      = '0;
    end else begin
      group_d = acc;
      cnt_d   = cnt_inc;
    end
  end

  assign out_valid_d = in_valid_q && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
      if (in_valid_q) begin
        group_q <= group_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && out_valid_d) begin
      out_word_q <= out_word_d;
      out_kind_q <= out_kind_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tuser_o  = out_kind_q;

  // assertions

  // a group never holds five digits
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < GroupLen)
    else $error("digit count out of range");

  // end and error beats carry a zero word
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == KIND_END || out_kind_q == KIND_ERR)
      |-> out_word_q == '0)
    else $error("end or error beat with nonzero word");

  // the fifth digit emits a word and restarts the group
  a_word_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance && dig.valid && cnt_q == GroupLen - CntW'(1)
      |=> out_valid_q && out_kind_q == KIND_WORD && cnt_q == '0 && group_q == '0)
    else $error("completed group not emitted");

  // a terminator at group start gives an end beat and stays at group start
  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance && cnt_q == '0 && in_char_q == CharEnd
      |=> out_valid_q && out_kind_q == KIND_END && cnt_q == '0)
    else $error("terminator not reported");

  // the group state only moves when the decode stage advances
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(cnt_q) && $stable(group_q))
    else $error("group state changed while stalled");

endmodule

>>> sim/base85_text_to_word_decoder_core_tb.sv
// self-checking testbench for base85_text_to_word_decoder_core: a directed
// table and random character streams, with every result beat checked in order
// depends on b85dec_pkg and base85_text_to_word_decoder_core
`timescale 1ns / 1ps

module base85_text_to_word_decoder_core_tb;
  import b85dec_pkg::*;

  localparam int unsigned RandChars = 1375;
  localparam int unsigned LongHold  = 400;   // one long receiver hold-off
  localparam int unsigned IdleLimit = 4000;  // watchdog, cycles with no beat
  localparam int unsigned MaxShown  = 10;

  // digit order of the base85 text alphabet
  localparam string Alpha85 =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_`{|}~";

  // how a stimulus row gets its expectation
  typedef enum logic [1:0] {
    EXP_MODEL = 2'd0,  // from the decoder model below
    EXP_NONE  = 2'd1,  // typed in: no result beat
    EXP_TYPED = 2'd2   // typed in: the result given in the row
  } exp_src_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    exp_src_e         src;
    logic [WordW-1:0] word;
    kind_e            kind;
  } char_row_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    kind_e            kind;
  } decode_res_t;

  localparam char_row_t DirTbl [25] = '{
    '{CharNul, EXP_NONE,  32'h0, KIND_WORD},  // nul at group start is skipped
    '{CharEnd, EXP_TYPED, 32'h0, KIND_END},   // terminator right after reset
    '{8'h30,   EXP_NONE,  32'h0, KIND_WORD},  // lowest digit five times
    '{8'h30,   EXP_NONE,  32'h0, KIND_WORD},
    '{8'h30,   EXP_NONE,  32'h0, KIND_WORD},
    '{8'h30,   EXP_NONE,  32'h0, KIND_WORD},
    '{8'h30,   EXP_TYPED, 32'h0, KIND_WORD},
    '{8'h7e,   EXP_MODEL, 32'h0, KIND_WORD},  // highest digit, value wraps
    '{8'h7e,   EXP_MODEL, 32'h0, KIND_WORD},
    '{8'h7e,   EXP_MODEL, 32'h0, KIND_WORD},
    '{8'h7e,   EXP_MODEL, 32'h0, KIND_WORD},
    '{8'h7e,   EXP_MODEL, 32'h0, KIND_WORD},
    '{CharEnd, EXP_TYPED, 32'h0, KIND_END},
    '{8'h30,   EXP_MODEL, 32'h0, KIND_WORD},  // nul inside a group is an error
    '{8'h7e,   EXP_MODEL, 32'h0, KIND_WORD},
    '{CharNul, EXP_TYPED, 32'h0, KIND_ERR},
    '{8'h41,   EXP_MODEL, 32'h0, KIND_WORD},  // terminator inside a group
    '{CharEnd, EXP_TYPED, 32'h0, KIND_ERR},
    '{8'hff,   EXP_TYPED, 32'h0, KIND_ERR},   // top byte, outside the alphabet
    '{8'h22,   EXP_TYPED, 32'h0, KIND_ERR},   // gap in the punctuation range
    '{8'h7a,   EXP_MODEL, 32'h0, KIND_WORD},  // mixed group across all ranges
    '{8'h21,   EXP_MODEL, 32'h0, KIND_WORD},
    '{8'h39,   EXP_MODEL, 32'h0, KIND_WORD},
    '{8'h5a,   EXP_MODEL, 32'h0, KIND_WORD},
    '{8'h7c,   EXP_MODEL, 32'h0, KIND_WORD}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [CharW-1:0] s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [WordW-1:0] m_tdata;
  logic [KindW-1:0] m_tuser;

  // decoder model state
  logic [WordW-1:0] grp_val = '0;
  logic [CntW-1:0]  grp_cnt = '0;

  char_row_t   stim_q[$];
  decode_res_t pending_q[$];

  int unsigned chars_in = 0;
  int unsigned mismatches = 0;
  int unsigned n_words = 0;
  int unsigned n_ends = 0;
  int unsigned n_errs = 0;

  always #5 clk_i = ~clk_i;

  base85_text_to_word_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] char_code
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [31:0] word_out
    .m_axis_tuser_o  (m_tuser)    // [1:0] kind
  );

  // position in the alphabet, or -1 for any other byte
  function automatic int alpha_digit(input logic [CharW-1:0] c);
    for (int k = 0; k < 85; k++) begin
      if (Alpha85[k] == c) return k;
    end
    return -1;
  endfunction

  // advance the decoder model by one character; returns 1 when a beat results
  function automatic bit decode_char(input logic [CharW-1:0] c, output decode_res_t res);
    int d;
    logic [WordW-1:0] v;
    res = '{word: '0, kind: KIND_WORD};
    if (grp_cnt == '0 && c == CharNul) return 1'b0;
    if (grp_cnt == '0 && c == CharEnd) begin
      grp_val = '0;
      res.kind = KIND_END;
      return 1'b1;
    end
    d = alpha_digit(c);
    if (d < 0) begin
      grp_val = '0;
      grp_cnt = '0;
      res.kind = KIND_ERR;
      return 1'b1;
    end
    v = grp_val * 32'd85 + WordW'(d);
    if (grp_cnt == GroupLen - 1'b1) begin
      res.word = {v[7:0], v[15:8], v[23:16], v[31:24]};
      grp_val = '0;
      grp_cnt = '0;
      return 1'b1;
    end
    grp_val = v;
    grp_cnt = grp_cnt + 1'b1;
    return 1'b0;
  endfunction

  // idle length: mostly none, sometimes a few cycles, rarely a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // every fourth stretch of 200 characters draws no random gaps on either side
  function automatic bit quiet_phase();
    return ((chars_in / 200) % 4) == 3;
  endfunction

  function automatic logic [CharW-1:0] rand_alpha();
    return Alpha85[$urandom_range(0, 84)];
  endfunction

  function automatic logic [CharW-1:0] rand_non_alpha();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255)); while (alpha_digit(c) >= 0);
    return c;
  endfunction

  // append one stimulus row at the tail of the stimulus list
  function automatic void add_row(input char_row_t row);
    stim_q.insert(stim_q.size(), row);
  endfunction

  // append one expected result beat at the tail of the scoreboard
  function automatic void add_expect(input decode_res_t res);
    pending_q.insert(pending_q.size(), res);
  endfunction

  function automatic void push_char(input logic [CharW-1:0] c);
    add_row('{ch: c, src: EXP_MODEL, word: '0, kind: KIND_WORD});
  endfunction

  // random part: mostly whole groups, some terminators, broken groups, noise
  function automatic void build_random();
    int unsigned r;
    int unsigned n;
    while (stim_q.size() < $size(DirTbl) + RandChars) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 9) == 0) push_char(CharNul);
        repeat (5) push_char(rand_alpha());
      end else if (r < 78) begin
        push_char(CharEnd);
      end else if (r < 88) begin
        n = $urandom_range(1, 4);
        repeat (n) push_char(rand_alpha());
        push_char(($urandom_range(0, 3) == 0) ? CharEnd : rand_non_alpha());
      end else begin
        push_char(CharW'($urandom_range(0, 255)));
      end
    end
  endfunction

  // offer one character after a random gap and wait for the handshake
  task automatic send_char(input char_row_t row);
    int unsigned gap;
    decode_res_t res;
    bit hit;
    gap = quiet_phase() ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= row.ch;
    do @(posedge clk_i); while (!s_tready);
    chars_in++;
    hit = decode_char(row.ch, res);
    case (row.src)
      EXP_TYPED: add_expect('{word: row.word, kind: row.kind});
      EXP_MODEL: if (hit) add_expect(res);
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxShown) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin : drain_results
    int unsigned stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && chars_in >= 600) begin
        m_tready <= 1'b0;
        held = 1'b1;
        repeat (LongHold) @(negedge clk_i);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!quiet_phase()) stall_left = pick_gap();
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    decode_res_t e;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat word=%h kind=%0d", m_tdata, m_tuser));
      end else begin
        e = pending_q.pop_front();
        if (m_tdata !== e.word || m_tuser !== e.kind)
          flag_mismatch($sformatf("expected word=%h kind=%0d, got word=%h kind=%0d",
                                  e.word, e.kind, m_tdata, m_tuser));
      end
      case (m_tuser)
        KIND_WORD: n_words++;
        KIND_END:  n_ends++;
        default:   n_errs++;
      endcase
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 IdleLimit, pending_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : run
    foreach (DirTbl[i]) add_row(DirTbl[i]);
    build_random();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (stim_q[i]) send_char(stim_q[i]);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    // pipeline of input and result registers, plus margin for a stray late beat
    repeat (8) @(posedge clk_i);
    $display("decoded %0d characters: %0d words, %0d end markers, %0d invalid characters",
             chars_in, n_words, n_ends, n_errs);
    $display("random gaps on both sides, one %0d-cycle output hold-off; %0d mismatches",
             LongHold, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/b85dec_pkg.sv
hw/rtl/base85_text_to_word_decoder_core.sv
sim/base85_text_to_word_decoder_core_tb.sv
